>>> rtl/can_over_udp_datagram_parser_assert.svh
// Assertion macros shared by the checker of the datagram parser.
// Depends on nothing; the using module supplies aclk and aresetn.
`ifndef CAN_OVER_UDP_DATAGRAM_PARSER_ASSERT_SVH
`define CAN_OVER_UDP_DATAGRAM_PARSER_ASSERT_SVH
// Same-cycle implication, off during reset.
`define CUDP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, off during reset.
`define CUDP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
// Next-cycle implication that also holds across reset.
`define CUDP_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/cudp_pkg.sv
// Types and codes of the CAN-over-UDP datagram parser.
// Used by every module of the block; depends on nothing.
package cudp_pkg;

    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_SHORT      = 4'd1;
    localparam logic [3:0] ST_BAD_MAGIC  = 4'd2;
    localparam logic [3:0] ST_DECL_LONG  = 4'd3;
    localparam logic [3:0] ST_CUT        = 4'd4;
    localparam logic [3:0] ST_LEFTOVER   = 4'd5;
    localparam logic [3:0] ST_BAD_IFACE  = 4'd6;
    localparam logic [3:0] ST_IFACE_DOWN = 4'd7;
    localparam logic [3:0] ST_SIZE_ERR   = 4'd8;

    localparam logic [31:0] MAGIC_WORD     = 32'h4332_4547;
    localparam logic [15:0] CAN_CHUNK_TYPE = 16'hc0fe;
    localparam int          HEADER_BYTES   = 16;
    localparam int          CHUNK_HDR      = 4;
    localparam int          MAX_PAYLOAD    = 64;

    localparam logic [0:0] REG_UP_MASK = 1'b0;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] frame_id;
        logic        interface_index;
        logic [6:0]  payload_length;
        logic [7:0]  fd_flags;
        logic [31:0] stamp_seconds;
        logic [31:0] stamp_nanoseconds;
        logic [7:0]  payload_byte;
        logic [3:0]  status;
        logic        sequence_gap;
        logic        last_of_frame;
    } result_t;

    // Results caused by one byte: one, or two when two is set.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } pair_t;

endpackage

>>> rtl/cudp_front.sv
// Front end: parses one datagram byte per cycle while input is accepted and forms its results.
// Depends on cudp_pkg.
module cudp_front #(
    parameter int MAX_DATAGRAM    = 1500,
    parameter int INTERFACE_COUNT = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      rx_byte,
    input  logic [10:0]     datagram_length,
    input  logic [1:0]      up_mask,
    output logic            push,
    output cudp_pkg::pair_t push_pair
);
    import cudp_pkg::*;

    logic [10:0] bp_reg, bp_next;
    logic [31:0] hs_reg, hs_next;
    logic [15:0] last_seq_reg, last_seq_next;
    logic [2:0]  st_reg, st_next;
    logic [15:0] cp_reg, cp_next;
    logic [15:0] csize_reg, csize_next;
    logic [15:0] ctype_reg, ctype_next;
    logic [63:0] f0_reg, f0_next;
    logic [63:0] f1_reg, f1_next;
    logic        dropped_reg, dropped_next;
    logic        gap_reg, gap_next;

    logic [10:0] len_eff, rem;
    logic        ending, chunk_hit, is_can;
    logic [16:0] cp_inc;
    logic [15:0] off;
    logic [7:0]  idx, plen;
    result_t     chunk_res, done_res;

    always_comb begin
        bp_next = bp_reg; hs_next = hs_reg; last_seq_next = last_seq_reg;
        st_next = st_reg; cp_next = cp_reg; csize_next = csize_reg;
        ctype_next = ctype_reg; f0_next = f0_reg; f1_next = f1_reg;
        dropped_next = dropped_reg; gap_next = gap_reg;
        chunk_hit = 1'b0; chunk_res = '0; done_res = '0;
        idx = f1_reg[31:24]; plen = f1_reg[15:8];
        is_can = (ctype_reg == CAN_CHUNK_TYPE);
        off = cp_reg - 16'(CHUNK_HDR);
        cp_inc = {1'b0, cp_reg} + 17'd1;

        len_eff = datagram_length;
        if (len_eff == 11'd0) len_eff = 11'd1;
        if (32'(len_eff) > MAX_DATAGRAM) len_eff = 11'(MAX_DATAGRAM);
        ending = ({1'b0, bp_reg} + 12'd1) >= {1'b0, len_eff};
        rem = (len_eff > bp_reg) ? len_eff - bp_reg : 11'd0;

        if (32'(bp_reg) < HEADER_BYTES) begin
            hs_next = {hs_reg[23:0], rx_byte};
            if (bp_reg == 11'd3 && hs_next != MAGIC_WORD && 32'(len_eff) >= HEADER_BYTES)
                st_next = 3'(ST_BAD_MAGIC);
            if (32'(bp_reg) == HEADER_BYTES - 1 && st_next == 3'(ST_OK)) begin
                if (hs_next[15:0] > {5'd0, len_eff}) begin
                    st_next = 3'(ST_DECL_LONG);
                end else begin
                    gap_next = (hs_next[31:16] != last_seq_reg + 16'd1);
                    last_seq_next = hs_next[31:16];
                end
            end
        end else if (st_reg == 3'(ST_OK)) begin
            if (cp_reg == 16'd0 && rem <= 11'd4) begin
                st_next = 3'(ST_LEFTOVER);
            end else if (32'(cp_reg) < CHUNK_HDR) begin
                hs_next = {hs_reg[23:0], rx_byte};
                cp_next = cp_inc[15:0];
                if (32'(cp_next) == CHUNK_HDR) begin
                    csize_next = hs_next[31:16];
                    ctype_next = hs_next[15:0];
                    f0_next = '0; f1_next = '0; dropped_next = 1'b0;
                    if (rem != 11'd0 && csize_next > {5'd0, rem - 11'd1}) begin
                        st_next = 3'(ST_CUT);
                    end else if (csize_next == 16'd0) begin
                        if (ctype_next == CAN_CHUNK_TYPE) begin
                            chunk_hit = 1'b1;
                            chunk_res.kind = KIND_DROP;
                            chunk_res.status = ST_SIZE_ERR;
                            dropped_next = 1'b1;
                        end
                        cp_next = 16'd0;
                    end
                end
            end else begin
                if (is_can) begin
                    if (off < 16'd8) begin
                        f0_next = {f0_reg[55:0], rx_byte};
                    end else if (32'(off) < HEADER_BYTES) begin
                        f1_next = {f1_reg[55:0], rx_byte};
                        if (32'(off) == HEADER_BYTES - 1) begin
                            idx = f1_next[31:24];
                            plen = f1_next[15:8];
                            chunk_hit = 1'b1;
                            if (32'(idx) >= INTERFACE_COUNT) begin
                                chunk_res.kind = KIND_DROP;
                                chunk_res.status = ST_BAD_IFACE;
                                dropped_next = 1'b1;
                            end else if (idx >= 8'd2 || !up_mask[idx[0]]) begin
                                chunk_res.kind = KIND_DROP;
                                chunk_res.status = ST_IFACE_DOWN;
                                dropped_next = 1'b1;
                            end else if (32'(plen) > MAX_PAYLOAD ||
                                         {8'd0, plen} + 16'(HEADER_BYTES) != csize_reg) begin
                                chunk_res.kind = KIND_DROP;
                                chunk_res.status = ST_SIZE_ERR;
                                dropped_next = 1'b1;
                            end else begin
                                chunk_res.kind = KIND_START;
                                chunk_res.frame_id = f1_next[63:32];
                                chunk_res.interface_index = idx[0];
                                chunk_res.payload_length = plen[6:0];
                                chunk_res.fd_flags = f1_next[7:0];
                                chunk_res.stamp_seconds = f0_reg[63:32];
                                chunk_res.stamp_nanoseconds = f0_reg[31:0];
                                chunk_res.last_of_frame = (plen == 8'd0);
                            end
                        end
                    end else if (!dropped_reg) begin
                        chunk_hit = 1'b1;
                        chunk_res.kind = KIND_DATA;
                        chunk_res.payload_byte = rx_byte;
                        chunk_res.last_of_frame = ({1'b0, off} + 17'd1) == {1'b0, csize_reg};
                    end
                end
                cp_next = cp_inc[15:0];
                if (cp_inc - 17'(CHUNK_HDR) >= {1'b0, csize_reg}) begin
                    // Chunk too short to hold a CAN fixed part: drop at its end.
                    if (is_can && 32'(csize_reg) < HEADER_BYTES) begin
                        chunk_hit = 1'b1;
                        chunk_res = '0;
                        chunk_res.kind = KIND_DROP;
                        chunk_res.status = ST_SIZE_ERR;
                        dropped_next = 1'b1;
                    end
                    cp_next = 16'd0;
                end
            end
        end

        done_res.kind = KIND_DONE;
        done_res.status = (32'(bp_reg) < HEADER_BYTES - 1) ? ST_SHORT : {1'b0, st_next};
        done_res.sequence_gap = (done_res.status == ST_OK) && gap_next;

        if (ending) begin
            bp_next = 11'd0; st_next = 3'(ST_OK); cp_next = 16'd0;
            dropped_next = 1'b0; gap_next = 1'b0;
        end else begin
            bp_next = bp_reg + 11'd1;
        end

        push_pair = '0;
        if (chunk_hit) begin
            push_pair.r0 = chunk_res;
            push_pair.r1 = done_res;
            push_pair.two = ending;
        end else begin
            push_pair.r0 = done_res;
        end
        push = in_accept && (chunk_hit || ending);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bp_reg <= '0; hs_reg <= '0; last_seq_reg <= '0; st_reg <= '0;
            cp_reg <= '0; csize_reg <= '0; ctype_reg <= '0; f0_reg <= '0;
            f1_reg <= '0; dropped_reg <= 1'b0; gap_reg <= 1'b0;
        end else if (in_accept) begin
            bp_reg <= bp_next; hs_reg <= hs_next; last_seq_reg <= last_seq_next;
            st_reg <= st_next; cp_reg <= cp_next; csize_reg <= csize_next;
            ctype_reg <= ctype_next; f0_reg <= f0_next; f1_reg <= f1_next;
            dropped_reg <= dropped_next; gap_reg <= gap_next;
        end
    end
endmodule

>>> rtl/cudp_queue.sv
// Four-entry queue of result pairs between front end and output stage.
// Depends on cudp_pkg.
module cudp_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  cudp_pkg::pair_t push_pair,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output cudp_pkg::pair_t head_pair
);
    import cudp_pkg::*;

    pair_t       mem_reg [4];
    logic [1:0]  wr_reg, rd_reg;
    logic [2:0]  count_reg;

    assign full      = (count_reg == 3'd4);
    assign empty     = (count_reg == 3'd0);
    assign head_pair = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_reg] <= push_pair;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg <= '0; rd_reg <= '0; count_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            count_reg <= count_reg + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule

>>> rtl/cudp_back.sv
// Output stage: splits queued pairs into single results on a register.
// Depends on cudp_pkg.
module cudp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              empty,
    input  cudp_pkg::pair_t   head_pair,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output cudp_pkg::result_t out_res
);
    import cudp_pkg::*;

    logic    valid_reg, valid_next;
    logic    sub_reg, sub_next;
    result_t res_reg, res_next;
    logic    load;

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        load = !valid_reg || out_ready;
        valid_next = valid_reg; sub_next = sub_reg; res_next = res_reg; pop = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                if (!sub_reg) begin
                    res_next = head_pair.r0;
                    sub_next = head_pair.two;
                    pop = !head_pair.two;
                end else begin
                    res_next = head_pair.r1;
                    sub_next = 1'b0;
                    pop = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0; sub_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next; sub_reg <= sub_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end
endmodule

>>> rtl/can_over_udp_datagram_parser.sv
// CAN-over-UDP datagram parser: top level with the register port.
// Depends on cudp_pkg, cudp_front, cudp_queue and cudp_back.
//
// Usage:
//   The s_ stream carries one datagram byte per request with the datagram's
//   total length; the m_ stream returns results: frame starts, frame data
//   bytes, chunk drops and one datagram-done result per datagram.
//   kind travels in m_tuser, last_of_frame in m_tlast.
// Flow:
//   One byte is taken every cycle while the queue is not full. A result
//   reaches m_ through the queue and the output register. A byte that
//   causes two results gives them on the output one after the other; the
//   four-entry queue absorbs that, and s_tready falls only while it is full.
// Reset:
//   aresetn low clears parser state, queue and output; the interface
//   mask returns to both interfaces up. No clearing pass is needed.
// Stall:
//   While m_tready is low the output register holds, the queue fills and
//   then s_tready drops; nothing is lost.
// Registers: interface_up_mask at byte address 0, written over APB by the user only while idle; not enforced.
module can_over_udp_datagram_parser #(
    parameter int MAX_DATAGRAM    = 1500,
    parameter int INTERFACE_COUNT = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // rx_byte[7:0], datagram_length[18:8], zero
    output logic         m_tvalid,
    input  logic         m_tready,
    // frame_id[31:0], interface_index[32], payload_length[39:33], fd_flags[47:40],
    // stamp_seconds[79:48], stamp_nanoseconds[111:80], payload_byte[119:112],
    // status[123:120], sequence_gap[124], zero
    output logic [127:0] m_tdata,
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [0:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import cudp_pkg::*;

    logic [1:0] mask_reg;
    logic       accept, push, full, empty, pop, out_valid;
    pair_t      push_pair, head_pair;
    result_t    out_res;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_UP_MASK) ? {30'd0, mask_reg} : 32'd0;

    // Take register writes in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 2'd3;
        end else if (psel && penable && pwrite && pready && paddr == REG_UP_MASK) begin
            mask_reg <= pwdata[1:0];
        end
    end

    // Hold off input only while the queue is full.
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    cudp_front #(
        .MAX_DATAGRAM    (MAX_DATAGRAM),
        .INTERFACE_COUNT (INTERFACE_COUNT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_accept       (accept),
        .rx_byte         (s_tdata[7:0]),
        .datagram_length (s_tdata[18:8]),
        .up_mask         (mask_reg),
        .push            (push),
        .push_pair       (push_pair)
    );

    cudp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_pair (push_pair),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head_pair (head_pair)
    );

    cudp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .empty     (empty),
        .head_pair (head_pair),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tvalid = out_valid;
    assign m_tuser  = out_res.kind;
    assign m_tlast  = out_res.last_of_frame;
    assign m_tdata  = {3'd0, out_res.sequence_gap, out_res.status, out_res.payload_byte,
                       out_res.stamp_nanoseconds, out_res.stamp_seconds, out_res.fd_flags,
                       out_res.payload_length, out_res.interface_index, out_res.frame_id};
endmodule

>>> rtl/cudp_checker.sv
// Port-level checker for the datagram parser, bound to the top level.
// Depends on cudp_pkg and can_over_udp_datagram_parser_assert.svh.
`include "can_over_udp_datagram_parser_assert.svh"
module cudp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic [1:0]   m_tuser,
    input logic         m_tlast
);
    import cudp_pkg::*;

    logic drop_code_ok;

    // A drop carries only an interface or size reason.
    assign drop_code_ok = m_tdata[123:120] == ST_BAD_IFACE || m_tdata[123:120] == ST_IFACE_DOWN
                          || m_tdata[123:120] == ST_SIZE_ERR;

    `CUDP_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result dropped under stall")
    `CUDP_ASSERT_NOW(a_done_no_last, m_tvalid && m_tuser == KIND_DONE, !m_tlast, "done marked last")
    `CUDP_ASSERT_NOW(a_drop_code, m_tvalid && m_tuser == KIND_DROP, drop_code_ok, "bad drop code")
    `CUDP_ASSERT_NOW(a_data_clean, m_tvalid && m_tuser == KIND_DATA, m_tdata[111:0] == 112'd0, "data result has frame fields")
    `CUDP_ASSERT_ALWAYS(a_reset_idle, !aresetn, !m_tvalid, "output valid after reset")
endmodule

bind can_over_udp_datagram_parser cudp_checker u_cudp_checker (.*);
